>>> src/sha256_stream_hash_assert.svh
// Assertion macros for the streaming SHA-256 block.
// Used by the port checker; no other dependencies.
`ifndef SHA256_STREAM_HASH_ASSERT_SVH
`define SHA256_STREAM_HASH_ASSERT_SVH
// Implication checked on every clock unless reset is asserted.
`define SHA_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SHA_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

>>> src/sha_pkg.sv
// Package for the streaming SHA-256 block: types, constants and round functions.
// No dependencies.
package sha_pkg;
    typedef enum logic [2:0] {
        ST_IDLE, ST_ROUND, ST_FOLD, ST_PAD, ST_OUT
    } t_state;

    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;

    typedef logic [31:0] t_word;

    function automatic t_word round_k(input logic [5:0] i);
        t_word k [64] = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction

    function automatic t_word init_vec(input logic [2:0] i);
        t_word v [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                         32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return v[i];
    endfunction

    function automatic t_word ror(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage

>>> src/sha_round.sv
// One SHA-256 round with in-place message schedule; shared by all 64 rounds.
// Depends on sha_pkg.
module sha_round (
    input  sha_pkg::t_word i_v [8],
    input  sha_pkg::t_word i_w [16],
    input  logic [5:0]     i_idx,
    output sha_pkg::t_word o_v [8],
    output sha_pkg::t_word o_w [16]
);
    import sha_pkg::*;
    t_word s0, s1, big0, big1, ch, maj, t1, wnew;

    always_comb begin
        // window holds sched[i..i+15]; w[0] is this round's word
        s0   = ror(i_w[1], 7) ^ ror(i_w[1], 18) ^ (i_w[1] >> 3);
        s1   = ror(i_w[14], 17) ^ ror(i_w[14], 19) ^ (i_w[14] >> 10);
        wnew = i_w[0] + s0 + i_w[9] + s1;
        big1 = ror(i_v[4], 6) ^ ror(i_v[4], 11) ^ ror(i_v[4], 25);
        ch   = (i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]);
        t1   = i_v[7] + big1 + ch + round_k(i_idx) + i_w[0];
        big0 = ror(i_v[0], 2) ^ ror(i_v[0], 13) ^ ror(i_v[0], 22);
        maj  = (i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]);
        o_v[7] = i_v[6]; o_v[6] = i_v[5]; o_v[5] = i_v[4];
        o_v[4] = i_v[3] + t1;
        o_v[3] = i_v[2]; o_v[2] = i_v[1]; o_v[1] = i_v[0];
        o_v[0] = t1 + big0 + maj;
        for (int j = 0; j < 15; j++) o_w[j] = i_w[j + 1];
        o_w[15] = wnew;
    end
endmodule

>>> src/sha256_stream_hash.sv
// Top level of the streaming SHA-256 hasher: word packing, padding sequencer, output.
// Depends on sha_pkg and sha_round.
//
// Message words enter big-endian, one beat per word; the word flagged last
// carries 0..4 valid leading bytes (5..7 count as 4). Each completed 64-byte
// block is folded by a single round unit used once per cycle: 64 rounds,
// then a fold step that adds the result into the chaining value. After the
// last word the padding and length are appended one word per cycle, giving
// one or two more blocks, and then the eight digest words leave on the output
// channel, word 0 first, digest_done set on word 7. The input is not ready
// while a block is being compressed, padded or emitted. No clearing pass
// after reset.
module sha256_stream_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic        o_digest_done
);
    import sha_pkg::*;

    t_state      r_state, n_state;
    t_word       r_h [8];
    t_word       r_v [8];
    t_word       r_w [16];
    t_word       rv_n [8];
    t_word       rw_n [16];
    logic [5:0]  r_cnt;      // round index
    logic [3:0]  r_fill;     // words in buffer
    logic [63:0] r_bits;
    logic [63:0] r_len;      // latched length for padding
    logic [3:0]  r_pad;      // length phase: 1 pending, 2 high half placed, 0 done
    logic        r_mark;     // 0x80 already placed
    logic        r_final;    // current compression belongs to padding
    logic [2:0]  r_oidx;

    sha_round u_round (.i_v(r_v), .i_w(r_w), .i_idx(r_cnt), .o_v(rv_n), .o_w(rw_n));

    logic [2:0]  cnt_sat;
    t_word       last_w;
    t_word       pad_w;
    logic        acc;

    always_comb begin
        cnt_sat = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
        unique case (cnt_sat)
            3'd0:    last_w = {PAD_MARK, 24'h0};
            3'd1:    last_w = {i_message_word[31:24], PAD_MARK, 16'h0};
            3'd2:    last_w = {i_message_word[31:16], PAD_MARK, 8'h0};
            3'd3:    last_w = {i_message_word[31:8], PAD_MARK};
            default: last_w = i_message_word;
        endcase
        // pad words: mark (if not placed), zeros, then length at words 14, 15;
        // a mark in word 14 pushes the length into the next block
        priority if (!r_mark)                      pad_w = {PAD_MARK, 24'h0};
        else if (r_fill == 4'd14)                  pad_w = r_len[63:32];
        else if (r_fill == 4'd15 && r_pad == 4'd2) pad_w = r_len[31:0];
        else                                       pad_w = '0;
    end

    assign o_ready = (r_state == ST_IDLE);
    assign acc     = i_valid && o_ready;
    assign o_valid = (r_state == ST_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_digest_done = (r_oidx == 3'd7);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (acc) begin
                // a full buffer always compresses first, mark or not
                if (r_fill == 4'd15)  n_state = ST_ROUND;
                else if (i_last_word) n_state = ST_PAD;
            end
            ST_PAD:   if (r_fill == 4'd15) n_state = ST_ROUND;
            ST_ROUND: if (r_cnt == 6'd63) n_state = ST_FOLD;
            ST_FOLD:  n_state = (r_final && r_mark && r_pad == 4'd0) ? ST_OUT
                              : (r_final ? ST_PAD : ST_IDLE);
            ST_OUT:   if (i_ready && r_oidx == 3'd7) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // r_pad != 0 flags that the length still has to be written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_bits  <= '0;
            r_cnt   <= '0;
            r_mark  <= 1'b0;
            r_final <= 1'b0;
            r_pad   <= '0;
            r_oidx  <= '0;
            for (int j = 0; j < 8; j++) r_h[j] <= init_vec(3'(j));
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: if (acc) begin
                    r_w[r_fill] <= i_last_word ? last_w : i_message_word;
                    r_fill <= r_fill + 4'd1;
                    if (i_last_word) begin
                        r_len   <= r_bits + {58'd0, cnt_sat, 3'd0};
                        r_mark  <= (cnt_sat != 3'd4);
                        r_final <= 1'b1;
                        r_pad   <= 4'd1;
                    end else begin
                        r_bits <= r_bits + 64'd32;
                    end
                    r_v <= r_h;
                    r_cnt <= '0;
                end
                ST_PAD: begin
                    r_w[r_fill] <= pad_w;
                    r_fill <= r_fill + 4'd1;
                    r_mark <= 1'b1;
                    if (r_fill == 4'd14 && r_mark) r_pad <= 4'd2;
                    else if (r_fill == 4'd15 && r_pad == 4'd2) r_pad <= 4'd0;
                    r_v <= r_h;
                    r_cnt <= '0;
                end
                ST_ROUND: begin
                    r_v <= rv_n;
                    r_w <= rw_n;
                    r_cnt <= r_cnt + 6'd1;
                end
                ST_FOLD: begin
                    for (int j = 0; j < 8; j++) r_h[j] <= r_h[j] + r_v[j];
                    if (r_final && r_mark && r_pad == 4'd0) r_oidx <= '0;
                end
                ST_OUT: if (i_ready) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        for (int j = 0; j < 8; j++) r_h[j] <= init_vec(3'(j));
                        r_bits  <= '0;
                        r_fill  <= '0;
                        r_final <= 1'b0;
                        r_mark  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

>>> src/sha_port_check.sv
// Port-level checker for the streaming SHA-256 block, bound to the top level.
// Depends on sha256_stream_hash_assert.svh.
`include "sha256_stream_hash_assert.svh"
module sha_port_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_digest_word,
    input logic        o_digest_done
);
    // never accept input while a digest is pending
    `SHA_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    // stalled output beat holds
    `SHA_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_digest_word))
    // after the done beat the block returns to ready
    `SHA_ASSERT_NXT(a_done_ready, i_clk, i_rst_n, o_valid && i_ready && o_digest_done, o_ready)
    // a non-done beat is followed by another beat
    `SHA_ASSERT_NXT(a_burst, i_clk, i_rst_n, o_valid && i_ready && !o_digest_done, o_valid)
endmodule

bind sha256_stream_hash sha_port_check u_check (.*);

>>> dv/sha256_digest_checker.sv
// Checker for the streaming SHA-256 hasher: watches both channels, predicts digests.
// Depends on sha_pkg for the word type; reports a failure count to the testbench top.
module sha256_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [31:0] o_digest_word,
    input  logic        o_digest_done,
    output int          fail_count,
    output int          pending_digests
);
    timeunit 1ns;
    timeprecision 1ps;
    import sha_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic        done;
    } t_digest_beat;

    localparam t_word K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam t_word IV_TAB [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
        32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    t_word        chain [8];
    t_word        blk [16];
    logic [5:0]   fill;
    logic [63:0]  bit_len;
    t_digest_beat digest_q [$];

    function automatic t_word rot(t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic fold_block();
        t_word w [64];
        t_word v [8];
        t_word t1, t2;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (rot(w[i-15], 7) ^ rot(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rot(w[i-2], 17) ^ rot(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rot(v[4], 6) ^ rot(v[4], 11) ^ rot(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
            t2 = (rot(v[0], 2) ^ rot(v[0], 13) ^ rot(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += v[i];
    endtask

    task automatic push_byte(logic [7:0] b);
        if (fill[1:0] == 2'd0) blk[fill[5:2]] = '0;
        blk[fill[5:2]] |= t_word'(b) << ((3 - fill[1:0]) * 8);
        if (fill == 6'd63) begin
            fold_block();
            fill = '0;
        end else begin
            fill = fill + 6'd1;
        end
    endtask

    task automatic absorb_beat(t_word word, logic [2:0] cnt, logic last);
        int          n;
        logic [63:0] len;
        n = !last ? 4 : (cnt > 3'd4 ? 4 : int'(cnt));
        for (int i = 0; i < n; i++) push_byte(word[(3 - i) * 8 +: 8]);
        bit_len += 64'(n * 8);
        if (last) begin
            len = bit_len;
            push_byte(8'h80);
            while (fill != 6'd56) push_byte(8'h00);
            for (int i = 0; i < 8; i++) push_byte(len[(7 - i) * 8 +: 8]);
            for (int i = 0; i < 8; i++) digest_q.push_back('{chain[i], i == 7});
            for (int i = 0; i < 8; i++) chain[i] = IV_TAB[i];
            bit_len = '0;
            fill    = '0;
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("checker: %s mismatch got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        for (int i = 0; i < 8; i++) chain[i] = IV_TAB[i];
        fill = '0;
        bit_len = '0;
    end

    assign pending_digests = digest_q.size();

    always @(posedge i_clk) begin
        t_digest_beat exp_beat;
        if (i_rst_n) begin
            if (i_valid && o_ready) absorb_beat(i_message_word, i_byte_count, i_last_word);
            if (o_valid && i_ready) begin
                if (digest_q.size() == 0) begin
                    report_mismatch("unexpected beat", o_digest_word, '0);
                end else begin
                    exp_beat = digest_q.pop_front();
                    if (o_digest_word !== exp_beat.word)
                        report_mismatch("digest_word", o_digest_word, exp_beat.word);
                    if (o_digest_done !== exp_beat.done)
                        report_mismatch("digest_done", 32'(o_digest_done),
                                        32'(exp_beat.done));
                end
            end
        end
    end
endmodule

>>> dv/tb_top.sv
// Testbench top for the streaming SHA-256 hasher: clock, reset, stimulus, verdict.
// Depends on sha256_stream_hash and sha256_digest_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_message_word = '0;
    logic [2:0]  i_byte_count = '0;
    logic        i_last_word = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_digest_word;
    logic        o_digest_done;
    int          fail_count;
    int          pending_digests;
    bit          stim_done = 1'b0;

    sha256_stream_hash uut (.*);

    sha256_digest_checker chk (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one; a quarter of the time none.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 25) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // Send one beat: drop valid for a gap if any, raise it with the payload at a
    // falling edge, hold until accepted; valid stays up until the next beat or idle.
    task automatic send_beat(logic [31:0] word, logic [2:0] cnt, logic last);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_message_word <= word;
        i_byte_count   <= cnt;
        i_last_word    <= last;
        i_valid        <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Send a message of n_words; the last one carries cnt bytes.
    task automatic send_message(int n_words, logic [2:0] cnt, bit fill_ones);
        logic [31:0] w;
        for (int i = 0; i < n_words; i++) begin
            w = fill_ones ? 32'hffffffff : $urandom();
            send_beat(w, i == n_words - 1 ? cnt : 3'($urandom_range(7)),
                      i == n_words - 1);
        end
    endtask

    // Receiver: stall at random, ready low for gap lengths.
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            g = gap_len();
            if (g > 0) begin
                i_ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(8)) @(negedge i_clk);
        end
    end

    initial begin
        int items;
        int n;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // Directed: empty message, each byte count, saturating counts,
        // all-ones and all-zeros words, block boundary lengths.
        send_beat(32'h0, 3'd0, 1'b1);
        send_beat(32'h61626364, 3'd3, 1'b1);
        for (int c = 1; c <= 7; c++) send_beat($urandom(), 3'(c), 1'b1);
        send_message(14, 3'd4, 1'b1);
        send_beat(32'h0, 3'd4, 1'b1);
        // Hold off until every digest beat has drained.
        i_valid <= 1'b0;
        wait (pending_digests == 0);
        repeat (100) @(negedge i_clk);
        send_message(16, 3'd0, 1'b0);
        send_message(16, 3'd4, 1'b0);
        send_message(13, 3'd2, 1'b1);
        items = 0;
        while (items < 330) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 15) : $urandom_range(6, 1);
            send_message(n, 3'($urandom_range(7)), $urandom_range(15) == 0);
            items += n;
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        wait (pending_digests == 0);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top: errors");
        $finish;
    end
endmodule

>>> sim.f
+incdir+src
src/sha_pkg.sv
src/sha_round.sv
src/sha256_stream_hash.sv
src/sha_port_check.sv
dv/sha256_digest_checker.sv
dv/tb_top.sv
